/* rtl/sler_pkg.sv */
// Shared types, key codes and result kinds for the serial line editor.
package sler_pkg;

   localparam int SLOTS_DEF      = 4;
   localparam int LINE_BYTES_DEF = 32;

   localparam logic [7:0] KEY_BACK    = 8'h08;
   localparam logic [7:0] KEY_LF      = 8'h0A;
   localparam logic [7:0] KEY_CR      = 8'h0D;
   localparam logic [7:0] KEY_ESC     = 8'h1B;
   localparam logic [7:0] KEY_SPACE   = 8'h20;
   localparam logic [7:0] KEY_UP      = 8'h41;
   localparam logic [7:0] KEY_BRACKET = 8'h5B;
   localparam logic [7:0] KEY_DEL     = 8'h7F;

   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_type;

endpackage

/* rtl/sler_ram.sv */
// Generic one-write, one-read synchronous RAM with registered read data.
module sler_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/serial_line_editor_with_recall.sv */
// Top level of the serial line editor: line ring, history line and control sequencer.
//
//   channel   | handshake                     | payload
//   ----------+-------------------------------+------------------------------------
//   request   | start in, busy out            | req_data  : action, rx_byte
//   result    | rsp_valid out, one cycle each | rsp_data  : out_kind, out_byte, last
//
// An ordinary byte, a line close with an empty line, or a take with nothing or an empty
// line waiting gives a single result; erasing a character echoes the key, a space and a
// backspace. A line close copies the line into the history memory, one byte a cycle. A
// take streams the slot out through the line memory read port. An arrow key checks the
// two previous bytes; a recall then emits the newline and copies the history line back
// byte by byte, or emits only the newline with an empty history.
// Reset clears the slot pointers, the length table and the history length; the two
// memories hold no reset value and are only read below a stored length.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module serial_line_editor_with_recall
   import sler_pkg::*;
#(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int SW         = $clog2(SLOTS);
   localparam int LW         = $clog2(LINE_BYTES);
   localparam int AW         = SW + LW;
   localparam int LINE_DEPTH = SLOTS * (1 << LW);
   localparam int HIST_DEPTH = 1 << LW;

   localparam logic [LW-1:0] LEN_MAX   = LW'(LINE_BYTES - 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_BS1    = 4'd1;
   localparam logic [3:0] S_BS2    = 4'd2;
   localparam logic [3:0] S_CHK0   = 4'd3;
   localparam logic [3:0] S_CHK1   = 4'd4;
   localparam logic [3:0] S_CHK2   = 4'd5;
   localparam logic [3:0] S_NL     = 4'd6;
   localparam logic [3:0] S_RECALL = 4'd7;
   localparam logic [3:0] S_COPY   = 4'd8;
   localparam logic [3:0] S_TAKE   = 4'd9;
   localparam logic [3:0] S_DRAIN  = 4'd10;

   // what to do with memory data that arrives in the cycle after its read
   localparam logic [1:0] P_TAKE   = 2'd0;
   localparam logic [1:0] P_COPY   = 2'd1;
   localparam logic [1:0] P_RECALL = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic [LW-1:0] lim_ff, lim_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [7:0]    byte_ff, byte_in;
   logic          esc_ok_ff, esc_ok_in;
   logic          pend_ff, pend_in;
   logic [1:0]    pend_mode_ff, pend_mode_in;
   logic [LW-1:0] pend_idx_ff, pend_idx_in;
   logic          pend_last_ff, pend_last_in;
   logic [SW-1:0] wslot_ff, wslot_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic [LW-1:0] hist_len_ff, hist_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [LW-1:0] len_ff [SLOTS];
   logic          len_we;
   logic [SW-1:0] len_sel;
   logic [LW-1:0] len_wdata;

   logic          line_we;
   logic [AW-1:0] line_waddr, line_raddr;
   logic [7:0]    line_wdata, line_rdata;
   logic          hist_we;
   logic [LW-1:0] hist_waddr, hist_raddr;
   logic [7:0]    hist_wdata, hist_rdata;

   logic          req_accept;
   logic [LW-1:0] cur_len, take_len;
   logic [SW-1:0] wslot_next, rslot_next;
   logic          issue_last;

   sler_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_waddr),
      .wr_data (line_wdata),
      .rd_addr (line_raddr),
      .rd_data (line_rdata)
   );

   sler_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   assign busy       = (state_ff != S_IDLE);
   assign req_accept = start & ~busy;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign cur_len    = len_ff[wslot_ff];
   assign take_len   = len_ff[rslot_ff];
   assign wslot_next = (wslot_ff == SLOT_LAST) ? '0 : wslot_ff + 1'b1;
   assign rslot_next = (rslot_ff == SLOT_LAST) ? '0 : rslot_ff + 1'b1;
   assign issue_last = (idx_ff == lim_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      lim_in       = lim_ff;
      slot_in      = slot_ff;
      byte_in      = byte_ff;
      esc_ok_in    = esc_ok_ff;
      pend_in      = 1'b0;
      pend_mode_in = pend_mode_ff;
      pend_idx_in  = pend_idx_ff;
      pend_last_in = pend_last_ff;
      wslot_in     = wslot_ff;
      rslot_in     = rslot_ff;
      hist_len_in  = hist_len_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      len_we       = 1'b0;
      len_sel      = wslot_ff;
      len_wdata    = '0;
      line_we      = 1'b0;
      line_waddr   = {slot_ff, lim_ff};
      line_wdata   = byte_ff;
      line_raddr   = {slot_ff, idx_ff};
      hist_we      = 1'b0;
      hist_waddr   = pend_idx_ff;
      hist_wdata   = line_rdata;
      hist_raddr   = idx_ff;

      // consume read data issued in the previous cycle
      if (pend_ff) begin
         case (pend_mode_ff)
            P_TAKE: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{KIND_LINE, line_rdata, pend_last_ff};
            end
            P_RECALL: begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{KIND_ECHO, hist_rdata, pend_last_ff};
               line_we      = 1'b1;
               line_waddr   = {slot_ff, pend_idx_ff};
               line_wdata   = hist_rdata;
            end
            P_COPY: begin
               hist_we = 1'b1;
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff) inside
         S_IDLE: begin
            if (req_accept) begin
               if (req_data.action) begin
                  if (rslot_ff == wslot_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{KIND_NONE, 8'h00, 1'b1};
                  end else begin
                     // free the oldest slot and stream it out, or report it empty
                     rslot_in  = rslot_next;
                     len_we    = 1'b1;
                     len_sel   = rslot_ff;
                     len_wdata = '0;
                     if (take_len == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{KIND_EMPTY, 8'h00, 1'b1};
                     end else begin
                        slot_in  = rslot_ff;
                        lim_in   = take_len;
                        idx_in   = '0;
                        state_in = S_TAKE;
                     end
                  end
               end else if (req_data.rx_byte == KEY_CR || req_data.rx_byte == KEY_LF) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{KIND_ECHO, req_data.rx_byte, 1'b1};
                  hist_len_in  = cur_len;
                  wslot_in     = wslot_next;
                  if (cur_len != '0) begin
                     slot_in  = wslot_ff;
                     lim_in   = cur_len;
                     idx_in   = '0;
                     state_in = S_COPY;
                  end
               end else if (req_data.rx_byte == KEY_BACK || req_data.rx_byte == KEY_DEL) begin
                  rsp_valid_in = 1'b1;
                  if (cur_len != '0) begin
                     rsp_data_in = '{KIND_ECHO, req_data.rx_byte, 1'b0};
                     len_we      = 1'b1;
                     len_wdata   = cur_len - 1'b1;
                     state_in    = S_BS1;
                  end else begin
                     rsp_data_in = '{KIND_ECHO, req_data.rx_byte, 1'b1};
                  end
               end else if (req_data.rx_byte == KEY_UP && cur_len >= LW'(2)) begin
                  // hold the echo until the escape prefix has been checked
                  slot_in  = wslot_ff;
                  lim_in   = cur_len;
                  byte_in  = req_data.rx_byte;
                  state_in = S_CHK0;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{KIND_ECHO, req_data.rx_byte, 1'b1};
                  if (cur_len < LEN_MAX) begin
                     line_we    = 1'b1;
                     line_waddr = {wslot_ff, cur_len};
                     line_wdata = req_data.rx_byte;
                     len_we     = 1'b1;
                     len_wdata  = cur_len + 1'b1;
                  end
               end
            end
         end
         S_BS1: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{KIND_ECHO, KEY_SPACE, 1'b0};
            state_in     = S_BS2;
         end
         S_BS2: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{KIND_ECHO, KEY_BACK, 1'b1};
            state_in     = S_IDLE;
         end
         S_CHK0: begin
            line_raddr = {slot_ff, lim_ff - LW'(2)};
            state_in   = S_CHK1;
         end
         S_CHK1: begin
            line_raddr = {slot_ff, lim_ff - 1'b1};
            esc_ok_in  = (line_rdata == KEY_ESC);
            state_in   = S_CHK2;
         end
         S_CHK2: begin
            rsp_valid_in = 1'b1;
            if (esc_ok_ff && line_rdata == KEY_BRACKET) begin
               rsp_data_in = '{KIND_ECHO, byte_ff, 1'b0};
               len_we      = 1'b1;
               len_sel     = slot_ff;
               len_wdata   = hist_len_ff;
               lim_in      = hist_len_ff;
               idx_in      = '0;
               state_in    = S_NL;
            end else begin
               rsp_data_in = '{KIND_ECHO, byte_ff, 1'b1};
               if (lim_ff < LEN_MAX) begin
                  line_we   = 1'b1;
                  len_we    = 1'b1;
                  len_sel   = slot_ff;
                  len_wdata = lim_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_NL: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{KIND_ECHO, KEY_LF, (lim_ff == '0)};
            state_in     = (lim_ff == '0) ? S_IDLE : S_RECALL;
         end
         S_TAKE, S_COPY, S_RECALL: begin
            // issue one read a cycle; the data is handled in the cycle after
            pend_in      = 1'b1;
            pend_idx_in  = idx_ff;
            pend_last_in = issue_last;
            pend_mode_in = (state_ff == S_TAKE) ? P_TAKE :
                           (state_ff == S_COPY) ? P_COPY : P_RECALL;
            if (issue_last) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         wslot_ff     <= '0;
         rslot_ff     <= '0;
         hist_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < SLOTS; s++) begin
            len_ff[s] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         wslot_ff     <= wslot_in;
         rslot_ff     <= rslot_in;
         hist_len_ff  <= hist_len_in;
         rsp_valid_ff <= rsp_valid_in;
         if (len_we) begin
            len_ff[len_sel] <= len_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      lim_ff       <= lim_in;
      slot_ff      <= slot_in;
      byte_ff      <= byte_in;
      esc_ok_ff    <= esc_ok_in;
      pend_mode_ff <= pend_mode_in;
      pend_idx_ff  <= pend_idx_in;
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // read data only ever arrives while the sequencer is still busy
   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> busy)
      else $error("memory data pending while idle");

   // a result that is not the last one leaves the block busy
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> busy)
      else $error("non-final result with sequencer idle");

   // empty and none results stand alone with a zero byte
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff.out_kind == KIND_EMPTY ||
                        rsp_data_ff.out_kind == KIND_NONE))
      |-> (rsp_data_ff.last && rsp_data_ff.out_byte == 8'h00))
      else $error("malformed empty or none result");

   // the read pointer moves only on an accepted take
   a_rslot_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_data.action) |=> (rslot_ff == $past(rslot_ff)))
      else $error("read slot moved without a take");

   // stored lengths never reach the line size
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      cur_len <= LEN_MAX)
      else $error("line length out of range");

endmodule
